### hdl/hsv_pkg.sv
// Shared constants and types for the HSV to RGB pixel converter.
// No dependencies; imported by every module of the block.
package hsv_pkg;

	// Default fraction width of the hue position inside a sector
	localparam int FRAC_BITS_DEF = 16;

	// Saturation and brightness are Q1.16
	localparam int IN_BITS = 16;
	localparam logic [16:0] UNIT_IN = 17'd65536;

	// Hue range: 46080 = 360 degrees, one sector = 60 degrees
	localparam logic [15:0] HUE_FULL   = 16'd46080;
	localparam logic [15:0] HUE_SECTOR = 16'd7680;
	localparam int REM_BITS = 13;

	// 7680 = 15 << 9: the sector divide is a shift then a divide by 15
	localparam int DIV_SHIFT  = 9;
	localparam int ODD_SHIFT  = 4;
	localparam int DIV_ODD    = (1 << ODD_SHIFT) - 1;

	// Register stages from input to output
	localparam int STAGES = 8;

	// Hue sectors
	localparam logic [2:0] SEC_R_Y = 3'd0;
	localparam logic [2:0] SEC_Y_G = 3'd1;
	localparam logic [2:0] SEC_G_C = 3'd2;
	localparam logic [2:0] SEC_C_B = 3'd3;
	localparam logic [2:0] SEC_B_M = 3'd4;
	localparam logic [2:0] SEC_M_R = 3'd5;

	// Per-pixel values that ride along the pipeline
	typedef struct packed {
		logic [2:0]  sector;
		logic [16:0] sat;
		logic [16:0] bright;
	} ctx_t;

	// Stage load enables and occupancy, from the pipeline control
	typedef struct packed {
		logic [STAGES:1] en;
		logic [STAGES:1] vld;
	} pipe_ctl_t;

endpackage

### hdl/hsv_norm.sv
// Stage 1: hue wrap, sector split and saturation/brightness clamp.
// Depends on hsv_pkg.
module hsv_norm (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hsv_pkg::pipe_ctl_t              ctl,
	input  logic [15:0]                     hue_angle,
	input  logic [16:0]                     sat_level,
	input  logic [16:0]                     bright_level,
	output hsv_pkg::ctx_t                   ctx_s1,
	output logic [hsv_pkg::REM_BITS-1:0]    rem_s1
);
	import hsv_pkg::*;

	localparam logic [15:0] B1 = HUE_SECTOR;
	localparam logic [15:0] B2 = 16'(2 * HUE_SECTOR);
	localparam logic [15:0] B3 = 16'(3 * HUE_SECTOR);
	localparam logic [15:0] B4 = 16'(4 * HUE_SECTOR);
	localparam logic [15:0] B5 = 16'(5 * HUE_SECTOR);

	logic [15:0] hue_w;
	logic [15:0] base;
	logic [15:0] rem_w;
	logic [2:0]  sector;
	logic [16:0] sat_c;
	logic [16:0] bright_c;

	// Wrap one full turn, then find the sector by compare
	always_comb begin
		hue_w = (hue_angle >= HUE_FULL) ? (hue_angle - HUE_FULL) : hue_angle;
		priority if (hue_w >= B5) begin
			sector = SEC_M_R;
			base   = B5;
		end else if (hue_w >= B4) begin
			sector = SEC_B_M;
			base   = B4;
		end else if (hue_w >= B3) begin
			sector = SEC_C_B;
			base   = B3;
		end else if (hue_w >= B2) begin
			sector = SEC_G_C;
			base   = B2;
		end else if (hue_w >= B1) begin
			sector = SEC_Y_G;
			base   = B1;
		end else begin
			sector = SEC_R_Y;
			base   = 16'd0;
		end
		rem_w = hue_w - base;
	end

	// Clamp to 1.0
	assign sat_c    = (sat_level > UNIT_IN) ? UNIT_IN : sat_level;
	assign bright_c = (bright_level > UNIT_IN) ? UNIT_IN : bright_level;

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			ctx_s1.sector <= sector;
			ctx_s1.sat    <= sat_c;
			ctx_s1.bright <= bright_c;
			rem_s1        <= rem_w[REM_BITS-1:0];
		end
	end

`ifndef ASSERT_OFF
	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.vld[1] |-> (rem_s1 < HUE_SECTOR[REM_BITS-1:0]) && (ctx_s1.sector <= SEC_M_R))
		else $error("hue split out of range");
`endif

endmodule

### hdl/hsv_frac.sv
// Stages 2-3: fraction f = floor(rem * 2^FRAC_BITS / 7680) by reciprocal
// multiply and one correction step. Depends on hsv_pkg.
module hsv_frac #(
	parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hsv_pkg::pipe_ctl_t              ctl,
	input  hsv_pkg::ctx_t                   ctx_s1,
	input  logic [hsv_pkg::REM_BITS-1:0]    rem_s1,
	output hsv_pkg::ctx_t                   ctx_s3,
	output logic [FRAC_BITS-1:0]            frac_s3
);
	import hsv_pkg::*;

	localparam int NW = REM_BITS + FRAC_BITS;
	localparam int MW = NW - DIV_SHIFT;
	localparam logic [MW-1:0] RECIP = MW'((64'd1 << MW) / 64'(DIV_ODD));

	logic [NW-1:0]     num;
	logic [MW-1:0]     m_in;
	logic [2*MW-1:0]   prod;
	ctx_t              ctx_s2;
	logic [MW-1:0]     m_s2;
	logic [FRAC_BITS-1:0] q0_s2;
	logic [MW-1:0]     q15;
	logic [MW-1:0]     resid;
	logic              corr;

	// Divide by 512 is a shift; the odd factor 15 goes by reciprocal
	assign num  = {rem_s1, {FRAC_BITS{1'b0}}};
	assign m_in = num[NW-1:DIV_SHIFT];
	assign prod = (2*MW)'(m_in) * (2*MW)'(RECIP);

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			ctx_s2 <= ctx_s1;
			m_s2   <= m_in;
			q0_s2  <= prod[MW+FRAC_BITS-1:MW];
		end
	end

	// Estimate is low by at most one
	assign q15   = {q0_s2, {ODD_SHIFT{1'b0}}} - MW'(q0_s2);
	assign resid = m_s2 - q15;
	assign corr  = (resid >= MW'(DIV_ODD));

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			ctx_s3  <= ctx_s2;
			frac_s3 <= q0_s2 + {{(FRAC_BITS-1){1'b0}}, corr};
		end
	end

`ifndef ASSERT_OFF
	a_recip_err: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.vld[2] |-> (resid < MW'(2 * DIV_ODD)))
		else $error("reciprocal estimate off by more than one");
`endif

endmodule

### hdl/hsv_mult.sv
// Stages 4-7: q and t products as exact fixed point, plus the v and p bytes.
// Wide products are split into two partial products. Depends on hsv_pkg.
module hsv_mult #(
	parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  hsv_pkg::pipe_ctl_t                           ctl,
	input  hsv_pkg::ctx_t                                ctx_s3,
	input  logic [FRAC_BITS-1:0]                         frac_s3,
	output hsv_pkg::ctx_t                                ctx_s7,
	output logic [7:0]                                   cv_s7,
	output logic [7:0]                                   cp_s7,
	output logic [2*hsv_pkg::IN_BITS+FRAC_BITS+1:0]      xq_s7,
	output logic [2*hsv_pkg::IN_BITS+FRAC_BITS+1:0]      xt_s7
);
	import hsv_pkg::*;

	localparam int DW = IN_BITS + 1 + FRAC_BITS;
	localparam int XW = IN_BITS + 1 + DW;
	localparam int LO = (DW + 1) / 2;
	localparam int HI = DW - LO;
	localparam int PW = 2 * (IN_BITS + 1);
	localparam logic [DW-1:0] ONE = {1'b1, {(IN_BITS+FRAC_BITS){1'b0}}};

	// stage 4
	logic [DW-1:0]     sf_w;
	logic [16:0]       ns_w;
	logic [PW-1:0]     pv_w;
	logic [24:0]       bv255;
	ctx_t              ctx_s4;
	logic [DW-1:0]     sf_s4;
	logic [16:0]       ns_s4;
	logic [PW-1:0]     pv_s4;
	logic [7:0]        cv_s4;
	// stage 5
	logic [PW+7:0]     pv255;
	ctx_t              ctx_s5;
	logic [DW-1:0]     dq_s5;
	logic [DW-1:0]     dt_s5;
	logic [7:0]        cv_s5;
	logic [7:0]        cp_s5;
	// stage 6
	ctx_t              ctx_s6;
	logic [IN_BITS+LO:0] pq_lo_s6;
	logic [IN_BITS+HI:0] pq_hi_s6;
	logic [IN_BITS+LO:0] pt_lo_s6;
	logic [IN_BITS+HI:0] pt_hi_s6;
	logic [7:0]        cv_s6;
	logic [7:0]        cp_s6;

	// s*f, 1-s, v(1-s), and the v byte
	assign sf_w  = DW'(ctx_s3.sat) * DW'(frac_s3);
	assign ns_w  = UNIT_IN - ctx_s3.sat;
	assign pv_w  = PW'(ctx_s3.bright) * PW'(ns_w);
	assign bv255 = {ctx_s3.bright, 8'd0} - 25'(ctx_s3.bright);

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			ctx_s4 <= ctx_s3;
			sf_s4  <= sf_w;
			ns_s4  <= ns_w;
			pv_s4  <= pv_w;
			cv_s4  <= bv255[IN_BITS+7:IN_BITS];
		end
	end

	// 1-sf and 1-s(1-f); the p byte from v(1-s)
	assign pv255 = {pv_s4, 8'd0} - (PW+8)'(pv_s4);

	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			ctx_s5 <= ctx_s4;
			dq_s5  <= ONE - sf_s4;
			dt_s5  <= {ns_s4, {FRAC_BITS{1'b0}}} + sf_s4;
			cv_s5  <= cv_s4;
			cp_s5  <= pv255[2*IN_BITS+7:2*IN_BITS];
		end
	end

	// v times each half of the q and t factors
	always_ff @(posedge clk) begin
		if (ctl.en[6]) begin
			ctx_s6   <= ctx_s5;
			pq_lo_s6 <= (IN_BITS+1+LO)'(ctx_s5.bright) * (IN_BITS+1+LO)'(dq_s5[LO-1:0]);
			pq_hi_s6 <= (IN_BITS+1+HI)'(ctx_s5.bright) * (IN_BITS+1+HI)'(dq_s5[DW-1:LO]);
			pt_lo_s6 <= (IN_BITS+1+LO)'(ctx_s5.bright) * (IN_BITS+1+LO)'(dt_s5[LO-1:0]);
			pt_hi_s6 <= (IN_BITS+1+HI)'(ctx_s5.bright) * (IN_BITS+1+HI)'(dt_s5[DW-1:LO]);
			cv_s6    <= cv_s5;
			cp_s6    <= cp_s5;
		end
	end

	// Recombine partial products
	always_ff @(posedge clk) begin
		if (ctl.en[7]) begin
			ctx_s7 <= ctx_s6;
			xq_s7  <= {pq_hi_s6, {LO{1'b0}}} + XW'(pq_lo_s6);
			xt_s7  <= {pt_hi_s6, {LO{1'b0}}} + XW'(pt_lo_s6);
			cv_s7  <= cv_s6;
			cp_s7  <= cp_s6;
		end
	end

`ifndef ASSERT_OFF
	a_factor_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.vld[5] |-> (cp_s5 <= cv_s5) && (dq_s5 <= ONE) && (dt_s5 <= ONE))
		else $error("p/q/t factor above v");
`endif

endmodule

### hdl/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB pixel converter: pipeline control and the
// final byte scaling and sector select. Depends on hsv_pkg, hsv_norm,
// hsv_frac and hsv_mult.
//
// Input channel: hue_angle, sat_level, bright_level with in_valid/in_stall.
// A request is taken at a rising edge where in_valid is high and in_stall
// is low. Output channel: red_out, green_out, blue_out with
// out_valid/out_stall, taken the same way.
//
// A request passes through the eight register stages (hue split, two
// reciprocal divide stages, four product stages, byte scale and select)
// before out_valid rises for its result. Throughput is one pixel per
// cycle while out_stall is low.
//
// Reset clears all stage valid bits; the pipeline comes up empty and ready.
// While out_stall is high the held result stays on the outputs, and
// earlier stages keep taking requests until every stage is full, at which
// point in_stall rises. Nothing is dropped or repeated.
module hsv_to_rgb_converter #(
	parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] hue_angle,
	input  logic [16:0] sat_level,
	input  logic [16:0] bright_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out
);
	import hsv_pkg::*;

	localparam int XW = 2 * IN_BITS + FRAC_BITS + 2;
	localparam int SH = 2 * IN_BITS + FRAC_BITS;

	pipe_ctl_t              ctl;
	logic [STAGES:1]        vld_q;
	logic [STAGES:1]        en;
	ctx_t                   ctx_s1;
	logic [REM_BITS-1:0]    rem_s1;
	ctx_t                   ctx_s3;
	logic [FRAC_BITS-1:0]   frac_s3;
	ctx_t                   ctx_s7;
	logic [7:0]             cv_s7;
	logic [7:0]             cp_s7;
	logic [XW-1:0]          xq_s7;
	logic [XW-1:0]          xt_s7;
	logic [XW+7:0]          xq255;
	logic [XW+7:0]          xt255;
	logic [7:0]             cq;
	logic [7:0]             ct;
	logic [7:0]             r_w;
	logic [7:0]             g_w;
	logic [7:0]             b_w;
	logic [7:0]             red_s8;
	logic [7:0]             green_s8;
	logic [7:0]             blue_s8;

	// A stage loads when it is empty or its successor moves
	always_comb begin
		en[STAGES] = !vld_q[STAGES] || !out_stall;
		for (int i = STAGES - 1; i >= 1; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign ctl.en  = en;
	assign ctl.vld = vld_q;
	assign in_stall  = !en[1];
	assign out_valid = vld_q[STAGES];

	// Valid bits follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int i = 2; i <= STAGES; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	hsv_norm u_norm (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.hue_angle    (hue_angle),
		.sat_level    (sat_level),
		.bright_level (bright_level),
		.ctx_s1       (ctx_s1),
		.rem_s1       (rem_s1)
	);

	hsv_frac #(.FRAC_BITS(FRAC_BITS)) u_frac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.ctx_s1  (ctx_s1),
		.rem_s1  (rem_s1),
		.ctx_s3  (ctx_s3),
		.frac_s3 (frac_s3)
	);

	hsv_mult #(.FRAC_BITS(FRAC_BITS)) u_mult (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.ctx_s3  (ctx_s3),
		.frac_s3 (frac_s3),
		.ctx_s7  (ctx_s7),
		.cv_s7   (cv_s7),
		.cp_s7   (cp_s7),
		.xq_s7   (xq_s7),
		.xt_s7   (xt_s7)
	);

	// Scale q and t by 255 and drop the fraction
	assign xq255 = {xq_s7, 8'd0} - (XW+8)'(xq_s7);
	assign xt255 = {xt_s7, 8'd0} - (XW+8)'(xt_s7);
	assign cq    = xq255[SH+7:SH];
	assign ct    = xt255[SH+7:SH];

	// Channel order per sector; zero saturation is grey
	always_comb begin
		unique case (ctx_s7.sector)
			SEC_R_Y: begin
				r_w = cv_s7; g_w = ct;    b_w = cp_s7;
			end
			SEC_Y_G: begin
				r_w = cq;    g_w = cv_s7; b_w = cp_s7;
			end
			SEC_G_C: begin
				r_w = cp_s7; g_w = cv_s7; b_w = ct;
			end
			SEC_C_B: begin
				r_w = cp_s7; g_w = cq;    b_w = cv_s7;
			end
			SEC_B_M: begin
				r_w = ct;    g_w = cp_s7; b_w = cv_s7;
			end
			default: begin
				r_w = cv_s7; g_w = cp_s7; b_w = cq;
			end
		endcase
		if (ctx_s7.sat == 17'd0) begin
			r_w = cv_s7;
			g_w = cv_s7;
			b_w = cv_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en[STAGES]) begin
			red_s8   <= r_w;
			green_s8 <= g_w;
			blue_s8  <= b_w;
		end
	end

	assign red_out   = red_s8;
	assign green_out = green_s8;
	assign blue_out  = blue_s8;

`ifndef ASSERT_OFF
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld_q) && out_stall)
		else $error("input stalled with a free stage");
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q == '0) && !in_valid |=> !out_valid)
		else $error("result out of an empty pipeline");
`endif

endmodule

### dv/testbench.sv
// Self-checking testbench for the HSV to RGB pixel converter (hsv_to_rgb_converter).
// A directed table and a random pixel stream are checked against a bit-exact predictor.
// Depends on hsv_pkg and the converter RTL.
module testbench;
	import hsv_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int CLK_HALF = 5;
	localparam int HOLD_CYCLES = 60;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SEGMENTS = 9;
	localparam int SEG_PIXELS = 170;
	localparam int N_DIRECTED = 24;

	typedef struct packed {
		logic [15:0] hue;
		logic [16:0] sat;
		logic [16:0] bright;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		pixel_t px;
		rgb_t   rgb;
	} conv_entry_t;

	typedef struct packed {
		pixel_t px;
		logic   fixed_exp;
		rgb_t   rgb;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] hue_angle = '0;
	logic [16:0] sat_level = '0;
	logic [16:0] bright_level = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;

	conv_entry_t rgb_due_q[$];
	int  err_cnt = 0;
	int  pixels_sent = 0;
	int  results_seen = 0;
	int  grey_cnt = 0;
	int  wrap_cnt = 0;
	int  clamp_cnt = 0;
	int  idle_cycles = 0;
	bit  in_idle = 1'b1;
	bit  out_idle = 1'b1;
	bit  hold_req = 1'b0;
	int  holds_done = 0;

	// Directed requests; rows marked fixed carry an expectation typed in by hand
	dir_row_t dir_rows [0:N_DIRECTED-1] = '{
		'{'{16'd0,     17'd0,      17'd0},      1'b1, '{8'd0,   8'd0,   8'd0}},
		'{'{16'd0,     17'd0,      17'd65536},  1'b1, '{8'd255, 8'd255, 8'd255}},
		'{'{16'd12345, 17'd0,      17'd131071}, 1'b1, '{8'd255, 8'd255, 8'd255}},
		'{'{16'd20000, 17'd65536,  17'd0},      1'b1, '{8'd0,   8'd0,   8'd0}},
		'{'{16'd0,     17'd65536,  17'd65536},  1'b1, '{8'd255, 8'd0,   8'd0}},
		'{'{16'd46080, 17'd65536,  17'd65536},  1'b1, '{8'd255, 8'd0,   8'd0}},
		'{'{16'd15360, 17'd65536,  17'd65536},  1'b1, '{8'd0,   8'd255, 8'd0}},
		'{'{16'd30720, 17'd65536,  17'd65536},  1'b1, '{8'd0,   8'd0,   8'd255}},
		'{'{16'd0,     17'd131071, 17'd65536},  1'b1, '{8'd255, 8'd0,   8'd0}},
		'{'{16'd23040, 17'd65536,  17'd65536},  1'b1, '{8'd0,   8'd255, 8'd255}},
		'{'{16'd38400, 17'd65536,  17'd65536},  1'b1, '{8'd255, 8'd0,   8'd255}},
		'{'{16'd65535, 17'd40000,  17'd60000},  1'b0, '0},
		'{'{16'd3840,  17'd32768,  17'd50000},  1'b0, '0},
		'{'{16'd11520, 17'd32768,  17'd50000},  1'b0, '0},
		'{'{16'd19200, 17'd32768,  17'd50000},  1'b0, '0},
		'{'{16'd26880, 17'd32768,  17'd50000},  1'b0, '0},
		'{'{16'd34560, 17'd32768,  17'd50000},  1'b0, '0},
		'{'{16'd42240, 17'd32768,  17'd50000},  1'b0, '0},
		'{'{16'd7679,  17'd65536,  17'd65536},  1'b0, '0},
		'{'{16'd7680,  17'd65536,  17'd65536},  1'b0, '0},
		'{'{16'd46079, 17'd65536,  17'd65536},  1'b0, '0},
		'{'{16'd10000, 17'd1,      17'd65536},  1'b0, '0},
		'{'{16'd25000, 17'd65536,  17'd1},      1'b0, '0},
		'{'{16'd40000, 17'd65535,  17'd65535},  1'b0, '0}
	};

	hsv_to_rgb_converter u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.hue_angle    (hue_angle),
		.sat_level    (sat_level),
		.bright_level (bright_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.red_out      (red_out),
		.green_out    (green_out),
		.blue_out     (blue_out)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// floor(255 * v * (1 - s*k)) from the exact fixed-point product
	function automatic logic [7:0] scaled_chan(logic [63:0] v, logic [63:0] s, logic [63:0] k);
		logic [63:0] one;
		logic [63:0] x;
		one = 64'd1 << (IN_BITS + FB);
		x = v * (one - s * k);
		return 8'((x * 64'd255) >> (2 * IN_BITS + FB));
	endfunction

	// Expected RGB bytes for one HSV pixel
	function automatic rgb_t hsv_to_rgb(pixel_t px);
		logic [63:0] h, s, v, rem, f, fone;
		logic [7:0]  cv, cp, cq, ct;
		logic [2:0]  sector;
		rgb_t        c;
		h = px.hue;
		s = px.sat;
		v = px.bright;
		fone = 64'd1 << FB;
		if (h >= HUE_FULL) h = h - HUE_FULL;
		if (s > UNIT_IN) s = UNIT_IN;
		if (v > UNIT_IN) v = UNIT_IN;
		cv = 8'((v * 64'd255) >> IN_BITS);
		if (s == 0) begin
			c = '{cv, cv, cv};
			return c;
		end
		sector = 3'(h / HUE_SECTOR);
		rem = h % HUE_SECTOR;
		f = (rem << FB) / HUE_SECTOR;
		cp = scaled_chan(v, s, fone);
		cq = scaled_chan(v, s, f);
		ct = scaled_chan(v, s, fone - f);
		case (sector)
			SEC_R_Y: c = '{cv, ct, cp};
			SEC_Y_G: c = '{cq, cv, cp};
			SEC_G_C: c = '{cp, cv, ct};
			SEC_C_B: c = '{cp, cq, cv};
			SEC_B_M: c = '{ct, cp, cv};
			default: c = '{cv, cp, cq};
		endcase
		return c;
	endfunction

	// Random level: favors zero, exactly one, over-range and tiny values
	function automatic logic [16:0] random_level();
		case ($urandom_range(0, 9))
			0: return 17'd0;
			1: return UNIT_IN;
			2: return 17'($urandom_range(65537, 131071));
			3: return 17'($urandom_range(1, 255));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		logic [15:0] off;
		case ($urandom_range(0, 9))
			// sector edges
			0: begin
				case ($urandom_range(0, 2))
					0: off = 16'd0;
					1: off = 16'd1;
					default: off = HUE_SECTOR - 16'd1;
				endcase
				px.hue = 16'($urandom_range(0, 5)) * HUE_SECTOR + off;
			end
			// 360 degrees and above wrap
			1: px.hue = 16'($urandom_range(46080, 65535));
			default: px.hue = 16'($urandom_range(0, 46079));
		endcase
		px.sat = random_level();
		px.bright = random_level();
		return px;
	endfunction

	// Drive one request, wait for it to be taken, then queue its expected result
	task automatic send_pixel(pixel_t px, logic fixed_exp, rgb_t fixed_rgb);
		int gap;
		conv_entry_t ent;
		gap = in_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		hue_angle <= px.hue;
		sat_level <= px.sat;
		bright_level <= px.bright;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		ent.px = px;
		ent.rgb = fixed_exp ? fixed_rgb : hsv_to_rgb(px);
		rgb_due_q.push_back(ent);
		pixels_sent++;
		if (px.sat == 0) grey_cnt++;
		if (px.hue >= HUE_FULL) wrap_cnt++;
		if (px.sat > UNIT_IN || px.bright > UNIT_IN) clamp_cnt++;
		@(negedge clk);
	endtask

	// Result side: random stalls, one long hold on request, compare in order
	initial begin : result_checker
		int stall_len;
		conv_entry_t ent;
		rgb_t got;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				stall_len = HOLD_CYCLES;
				holds_done++;
			end else begin
				stall_len = out_idle ? $urandom_range(0, 5) : 0;
			end
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			got = '{red_out, green_out, blue_out};
			results_seen++;
			if (rgb_due_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected result rgb %0d,%0d,%0d", got.red, got.green, got.blue);
			end else begin
				ent = rgb_due_q.pop_front();
				if (got.red !== ent.rgb.red || got.green !== ent.rgb.green ||
				    got.blue !== ent.rgb.blue) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("mismatch hsv %0d/%0d/%0d: expected rgb %0d,%0d,%0d got %0d,%0d,%0d",
							ent.px.hue, ent.px.sat, ent.px.bright,
							ent.rgb.red, ent.rgb.green, ent.rgb.blue,
							got.red, got.green, got.blue);
				end
			end
			@(negedge clk);
		end
	end

	// Watchdog: too long without any request taken on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: %0d results still outstanding", rgb_due_q.size());
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Stimulus: reset, directed table, then random segments with varying idle modes
	initial begin : stimulus
		int seg;
		int n;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_rows[i])
			send_pixel(dir_rows[i].px, dir_rows[i].fixed_exp, dir_rows[i].rgb);
		for (seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				1: begin in_idle = 1'b0; out_idle = 1'b1; end
				3: begin in_idle = 1'b1; out_idle = 1'b0; end
				4: begin in_idle = 1'b0; out_idle = 1'b0; end
				default: begin in_idle = 1'b1; out_idle = 1'b1; end
			endcase
			// long output hold with the input kept busy, so the pipe fills up
			if (seg == 2 || seg == 6) begin
				in_idle = 1'b0;
				hold_req = 1'b1;
			end
			for (n = 0; n < SEG_PIXELS; n++)
				send_pixel(random_pixel(), 1'b0, '0);
		end
		in_valid <= 1'b0;
		while (rgb_due_q.size() != 0) @(posedge clk);
		repeat (STAGES + 4) @(posedge clk);
		$display("converted %0d pixels (%0d from the directed table), %0d results compared",
			pixels_sent, N_DIRECTED, results_seen);
		$display("grey %0d, hue wrap %0d, level clamp %0d, long output holds %0d, errors %0d",
			grey_cnt, wrap_cnt, clamp_cnt, holds_done, err_cnt);
		if (err_cnt == 0 && rgb_due_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### files.f
hdl/hsv_pkg.sv
hdl/hsv_norm.sv
hdl/hsv_frac.sv
hdl/hsv_mult.sv
hdl/hsv_to_rgb_converter.sv
dv/testbench.sv
